/* design/lufpp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lufpp_pkg
// Shared types, codes and helpers of the LU factoring block.
// ----------------------------------------------------------------------------
package lufpp_pkg;

   localparam int DATA_W     = 32;
   localparam int IDX_PORT_W = 4;
   localparam int SIZE_W     = 5;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
   localparam int DIV_BITS   = 48;
   localparam int DIV_CNT_W  = $clog2(DIV_BITS + 1);
   localparam int FRAC_W     = 16;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RD,
      S_INIT,
      S_PV_RD,
      S_PV_CMP,
      S_PV_CHK,
      S_SW_RA,
      S_SW_RB,
      S_SW_WA,
      S_SW_WB,
      S_PR_RD,
      S_PR_CAP,
      S_L_RD,
      S_L_GO,
      S_L_WAIT,
      S_L_WR,
      S_U_RA,
      S_U_RB,
      S_U_RC,
      S_U_WR
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_READ,
      OP_RSP,
      OP_INIT,
      OP_PV_RD,
      OP_PV_CMP,
      OP_SING,
      OP_SW_RA,
      OP_SW_RB,
      OP_SW_WA,
      OP_SW_WB,
      OP_PR_RD,
      OP_PR_CAP,
      OP_L_RD,
      OP_L_GO,
      OP_L_WR,
      OP_U_RA,
      OP_U_RB,
      OP_U_RC,
      OP_U_WR
   } op_type;

   typedef struct packed {
      op_type op;
      logic   first;    // pivot scan is at the diagonal row
      logic   perm_en;  // swap pass is at column zero, move the permutation too
   } cmd_type;

   typedef struct packed {
      logic best_is_i;
      logic bmag_zero;
      logic div_busy;
      logic rsp_free;
   } sts_type;

   function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
      return r;
   endfunction

endpackage : lufpp_pkg
`default_nettype wire

/* design/lufpp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lufpp request and response channels
// Valid/ready channels carrying one request item and one response item.
// ----------------------------------------------------------------------------
interface lufpp_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [3:0]  row;
   logic [3:0]  col;
   logic signed [31:0] value;
   logic        last;

   modport source (output valid, func, row, col, value, last, input ready);
   modport sink   (input valid, func, row, col, value, last, output ready);
endinterface : lufpp_req_if

interface lufpp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] entry;
   logic [3:0]  pivot_row;
   logic        singular;

   modport source (output valid, entry, pivot_row, singular, input ready);
   modport sink   (input valid, entry, pivot_row, singular, output ready);
endinterface : lufpp_rsp_if
`default_nettype wire

/* design/lufpp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lufpp_div
// Radix-2 restoring divider: (a * 2^16) / d, rounded toward zero, saturated.
// ----------------------------------------------------------------------------
module lufpp_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] dividend,
   input  wire logic signed [31:0] divisor,
   output logic                    busy,
   output logic signed [31:0]      quot
);

   localparam int NB = lufpp_pkg::DIV_BITS;

   logic [NB-1:0]  num_ff, num_in;
   logic [31:0]    rem_ff, rem_in;
   logic [31:0]    den_ff, den_in;
   logic           neg_ff, neg_in;
   logic           busy_ff, busy_in;
   logic [lufpp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [32:0]    rem_sh;
   logic [32:0]    diff;
   logic [NB-1:0]  neg_q;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NB-1]};
      diff    = rem_sh - {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         num_in  = {lufpp_pkg::mag32(dividend), 16'd0};
         rem_in  = '0;
         den_in  = lufpp_pkg::mag32(divisor);
         neg_in  = dividend[31] ^ divisor[31];
         busy_in = 1'b1;
         cnt_in  = lufpp_pkg::DIV_CNT_W'(NB);
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            num_in = {num_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            num_in = {num_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - lufpp_pkg::DIV_CNT_W'(1);
         if (cnt_ff == lufpp_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // sign and clamp of the unsigned quotient
   always_comb begin
      neg_q = -num_ff;
      if (neg_ff) begin
         if (num_ff > NB'(48'h0000_8000_0000)) quot = 32'sh8000_0000;
         else quot = neg_q[31:0];
      end else begin
         if (num_ff > NB'(48'h0000_7FFF_FFFF)) quot = 32'sh7FFF_FFFF;
         else quot = num_ff[31:0];
      end
   end

   assign busy = busy_ff;

endmodule : lufpp_div
`default_nettype wire

/* design/lufpp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lufpp_dp
// Datapath: matrix memory, permutation memory, pivot search, update pipe, output.
// ----------------------------------------------------------------------------
module lufpp_dp #(
   parameter int MAX_DIM = 16,
   parameter int IDX_W   = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lufpp_pkg::cmd_type cmd,
   input  wire logic [IDX_W-1:0]   i_idx,
   input  wire logic [IDX_W-1:0]   j_idx,
   input  wire logic [IDX_W-1:0]   k_idx,
   input  wire logic [3:0]         req_row,
   input  wire logic [3:0]         req_col,
   input  wire logic signed [31:0] req_value,
   output lufpp_pkg::sts_type      sts,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_entry,
   output logic [3:0]              rsp_pivot_row,
   output logic                    rsp_singular
);

   localparam int ADDR_W = 2 * IDX_W;

   // addressed as {row, col}, so the depth covers the full index space
   logic signed [31:0] mem [2**ADDR_W];
   logic [IDX_W-1:0]   perm_mem [MAX_DIM];
   logic [MAX_DIM-1:0] pvld_ff, pvld_in;

   logic signed [31:0] mem_rd_ff;
   logic [IDX_W-1:0]   perm_rd_ff;
   logic               pvld_rd_ff;
   logic [IDX_W-1:0]   paddr_rd_ff;
   logic [IDX_W-1:0]   pval;

   logic signed [31:0] tmp_ff;
   logic [IDX_W-1:0]   ptmp_ff;
   logic [31:0]        bmag_ff;
   logic [IDX_W-1:0]   best_ff;
   logic signed [31:0] piv_ff;
   logic signed [31:0] l_ff;
   logic signed [63:0] prod_ff;
   logic signed [47:0] p_ff;
   logic               sing_ff;
   logic               rd_in_ff;
   logic               rd_rowok_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_entry_ff;
   logic [3:0]         rsp_prow_ff;
   logic               rsp_sing_ff;

   logic [31:0]        row32, col32;
   logic [IDX_W-1:0]   req_r, req_c;
   logic               req_inside, req_rowok;

   logic               m_re, m_we, p_re, p_we;
   logic [IDX_W-1:0]   m_rr, m_rc, m_wr, m_wc, p_ra, p_wa, p_wd;
   logic signed [31:0] m_wd;

   logic               div_busy;
   logic signed [31:0] div_q;
   logic signed [63:0] prod_sh;
   logic signed [47:0] p_rnd;
   logic signed [48:0] diff49;
   logic signed [31:0] upd_val;
   logic [31:0]        rd_mag;
   logic [31:0]        pval32;

   assign row32      = {28'd0, req_row};
   assign col32      = {28'd0, req_col};
   assign req_r      = row32[IDX_W-1:0];
   assign req_c      = col32[IDX_W-1:0];
   assign req_rowok  = row32 < 32'(MAX_DIM);
   assign req_inside = req_rowok && (col32 < 32'(MAX_DIM));

   // read port select
   always_comb begin
      m_re = 1'b0;
      m_rr = i_idx;
      m_rc = i_idx;
      p_re = 1'b0;
      p_ra = i_idx;
      unique case (cmd.op)
         lufpp_pkg::OP_READ: begin
            m_re = 1'b1; m_rr = req_r; m_rc = req_c;
            p_re = 1'b1; p_ra = req_r;
         end
         lufpp_pkg::OP_PV_RD: begin
            m_re = 1'b1; m_rr = j_idx; m_rc = i_idx;
         end
         lufpp_pkg::OP_SW_RA: begin
            m_re = 1'b1; m_rr = i_idx; m_rc = k_idx;
            p_re = 1'b1; p_ra = i_idx;
         end
         lufpp_pkg::OP_SW_RB: begin
            m_re = 1'b1; m_rr = best_ff; m_rc = k_idx;
            p_re = 1'b1; p_ra = best_ff;
         end
         lufpp_pkg::OP_PR_RD: begin
            m_re = 1'b1; m_rr = i_idx; m_rc = i_idx;
         end
         lufpp_pkg::OP_L_RD: begin
            m_re = 1'b1; m_rr = j_idx; m_rc = i_idx;
         end
         lufpp_pkg::OP_U_RA: begin
            m_re = 1'b1; m_rr = i_idx; m_rc = k_idx;
         end
         lufpp_pkg::OP_U_RB: begin
            m_re = 1'b1; m_rr = j_idx; m_rc = k_idx;
         end
         default: begin
         end
      endcase
   end

   // write port select
   always_comb begin
      m_we = 1'b0;
      m_wr = j_idx;
      m_wc = k_idx;
      m_wd = upd_val;
      p_we = 1'b0;
      p_wa = i_idx;
      p_wd = pval;
      unique case (cmd.op)
         lufpp_pkg::OP_LOAD: begin
            m_we = req_inside; m_wr = req_r; m_wc = req_c; m_wd = req_value;
         end
         lufpp_pkg::OP_SW_WA: begin
            m_we = 1'b1; m_wr = i_idx; m_wc = k_idx; m_wd = mem_rd_ff;
            p_we = cmd.perm_en; p_wa = i_idx; p_wd = pval;
         end
         lufpp_pkg::OP_SW_WB: begin
            m_we = 1'b1; m_wr = best_ff; m_wc = k_idx; m_wd = tmp_ff;
            p_we = cmd.perm_en; p_wa = best_ff; p_wd = ptmp_ff;
         end
         lufpp_pkg::OP_L_WR: begin
            m_we = 1'b1; m_wr = j_idx; m_wc = i_idx; m_wd = div_q;
         end
         lufpp_pkg::OP_U_WR: begin
            m_we = 1'b1; m_wr = j_idx; m_wc = k_idx; m_wd = upd_val;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (m_we) mem[{m_wr, m_wc}] <= m_wd;
      if (m_re) mem_rd_ff <= mem[ADDR_W'({m_rr, m_rc})];
   end

   always_ff @(posedge clock) begin
      if (p_we) perm_mem[p_wa] <= p_wd;
      if (p_re) begin
         perm_rd_ff  <= perm_mem[p_ra];
         pvld_rd_ff  <= pvld_ff[p_ra];
         paddr_rd_ff <= p_ra;
      end
   end

   // an entry never written since factoring start holds its own index
   assign pval = pvld_rd_ff ? perm_rd_ff : paddr_rd_ff;

   always_comb begin
      pvld_in = pvld_ff;
      if (cmd.op == lufpp_pkg::OP_INIT) pvld_in = '0;
      else if (p_we) pvld_in[p_wa] = 1'b1;
   end

   assign rd_mag = lufpp_pkg::mag32(mem_rd_ff);

   // update arithmetic: truncate product toward zero, subtract, clamp
   assign prod_sh = prod_ff >>> lufpp_pkg::FRAC_W;
   assign p_rnd   = prod_sh[47:0] +
                    48'((prod_ff[63] && (prod_ff[15:0] != 16'd0)) ? 1 : 0);
   assign diff49  = {{17{mem_rd_ff[31]}}, mem_rd_ff} - {p_ff[47], p_ff};
   always_comb begin
      if (diff49 > 49'sd2147483647) upd_val = 32'sh7FFF_FFFF;
      else if (diff49 < -49'sd2147483648) upd_val = 32'sh8000_0000;
      else upd_val = diff49[31:0];
   end

   lufpp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == lufpp_pkg::OP_L_GO),
      .dividend (mem_rd_ff),
      .divisor  (piv_ff),
      .busy     (div_busy),
      .quot     (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= '0;
         sing_ff <= 1'b0;
      end else begin
         pvld_ff <= pvld_in;
         if (cmd.op == lufpp_pkg::OP_INIT) sing_ff <= 1'b0;
         else if (cmd.op == lufpp_pkg::OP_SING) sing_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         lufpp_pkg::OP_READ: begin
            rd_in_ff    <= req_inside;
            rd_rowok_ff <= req_rowok;
         end
         lufpp_pkg::OP_PV_CMP: begin
            if (cmd.first || (rd_mag > bmag_ff)) begin
               bmag_ff <= rd_mag;
               best_ff <= j_idx;
            end
         end
         lufpp_pkg::OP_SW_RB: begin
            tmp_ff  <= mem_rd_ff;
            ptmp_ff <= pval;
         end
         lufpp_pkg::OP_PR_CAP: piv_ff <= mem_rd_ff;
         lufpp_pkg::OP_L_WR:   l_ff <= div_q;
         lufpp_pkg::OP_U_RB:   prod_ff <= l_ff * mem_rd_ff;
         lufpp_pkg::OP_U_RC:   p_ff <= p_rnd;
         default: begin
         end
      endcase
   end

   // output register
   assign pval32 = 32'(pval);
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == lufpp_pkg::OP_RSP) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == lufpp_pkg::OP_RSP) begin
         rsp_entry_ff <= rd_in_ff ? mem_rd_ff : 32'sd0;
         rsp_prow_ff  <= rd_rowok_ff ? pval32[3:0] : 4'd0;
         rsp_sing_ff  <= sing_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_entry     = rsp_entry_ff;
   assign rsp_pivot_row = rsp_prow_ff;
   assign rsp_singular  = rsp_sing_ff;

   assign sts.best_is_i = (best_ff == i_idx);
   assign sts.bmag_zero = (bmag_ff == 32'd0);
   assign sts.div_busy  = div_busy;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

endmodule : lufpp_dp
`default_nettype wire

/* design/lufpp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lufpp_ctrl
// Sequencer: request decode, loop counters and the factoring state machine.
// ----------------------------------------------------------------------------
module lufpp_ctrl #(
   parameter int MAX_DIM = 16,
   parameter int IDX_W   = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [4:0]         csr_wdata,
   input  wire logic               req_valid,
   input  wire logic               req_func,
   input  wire logic               req_last,
   output logic                    req_ready,
   input  wire lufpp_pkg::sts_type sts,
   output lufpp_pkg::cmd_type      cmd,
   output logic [IDX_W-1:0]        i_idx,
   output logic [IDX_W-1:0]        j_idx,
   output logic [IDX_W-1:0]        k_idx
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);

   lufpp_pkg::state_type state_ff, state_in;
   logic [lufpp_pkg::SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0] n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CNT_W-1:0] i_nx, j_nx, k_nx, n_eff;
   logic [31:0]      size32;
   logic             fire;

   assign fire   = req_valid && (state_ff == lufpp_pkg::S_IDLE);
   assign i_nx   = i_ff + CNT_W'(1);
   assign j_nx   = j_ff + CNT_W'(1);
   assign k_nx   = k_ff + CNT_W'(1);
   assign size32 = {27'd0, size_ff};

   always_comb begin
      if (size32 == 32'd0) n_eff = CNT_W'(1);
      else if (size32 > 32'(MAX_DIM)) n_eff = CNT_W'(MAX_DIM);
      else n_eff = CNT_W'(size32);
   end

   always_ff @(posedge clock) begin
      if (reset) size_ff <= lufpp_pkg::SIZE_RESET;
      else if (csr_we) size_ff <= csr_wdata;
   end

   // next state and loop counters
   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      unique case (state_ff)
         lufpp_pkg::S_IDLE: begin
            if (fire) begin
               if (req_func == lufpp_pkg::FUNC_READ) state_in = lufpp_pkg::S_RD;
               else if (req_last) state_in = lufpp_pkg::S_INIT;
            end
         end
         lufpp_pkg::S_RD: begin
            if (sts.rsp_free) state_in = lufpp_pkg::S_IDLE;
         end
         lufpp_pkg::S_INIT: begin
            n_in = n_eff;
            i_in = '0;
            j_in = '0;
            state_in = lufpp_pkg::S_PV_RD;
         end
         lufpp_pkg::S_PV_RD: state_in = lufpp_pkg::S_PV_CMP;
         lufpp_pkg::S_PV_CMP: begin
            if (j_nx < n_ff) begin
               j_in = j_nx;
               state_in = lufpp_pkg::S_PV_RD;
            end else begin
               state_in = lufpp_pkg::S_PV_CHK;
            end
         end
         lufpp_pkg::S_PV_CHK: begin
            priority if (sts.bmag_zero) begin
               // empty pivot column: skip it
               if (i_nx < n_ff) begin
                  i_in = i_nx; j_in = i_nx; state_in = lufpp_pkg::S_PV_RD;
               end else begin
                  state_in = lufpp_pkg::S_IDLE;
               end
            end else if (!sts.best_is_i) begin
               k_in = '0;
               state_in = lufpp_pkg::S_SW_RA;
            end else begin
               state_in = lufpp_pkg::S_PR_RD;
            end
         end
         lufpp_pkg::S_SW_RA: state_in = lufpp_pkg::S_SW_RB;
         lufpp_pkg::S_SW_RB: state_in = lufpp_pkg::S_SW_WA;
         lufpp_pkg::S_SW_WA: state_in = lufpp_pkg::S_SW_WB;
         lufpp_pkg::S_SW_WB: begin
            if (k_nx < n_ff) begin
               k_in = k_nx; state_in = lufpp_pkg::S_SW_RA;
            end else begin
               state_in = lufpp_pkg::S_PR_RD;
            end
         end
         lufpp_pkg::S_PR_RD: state_in = lufpp_pkg::S_PR_CAP;
         lufpp_pkg::S_PR_CAP: begin
            if (i_nx < n_ff) begin
               j_in = i_nx; state_in = lufpp_pkg::S_L_RD;
            end else begin
               state_in = lufpp_pkg::S_IDLE;
            end
         end
         lufpp_pkg::S_L_RD: state_in = lufpp_pkg::S_L_GO;
         lufpp_pkg::S_L_GO: state_in = lufpp_pkg::S_L_WAIT;
         lufpp_pkg::S_L_WAIT: begin
            if (!sts.div_busy) state_in = lufpp_pkg::S_L_WR;
         end
         lufpp_pkg::S_L_WR: begin
            // j is below i, so the trailing column range is never empty
            k_in = i_nx;
            state_in = lufpp_pkg::S_U_RA;
         end
         lufpp_pkg::S_U_RA: state_in = lufpp_pkg::S_U_RB;
         lufpp_pkg::S_U_RB: state_in = lufpp_pkg::S_U_RC;
         lufpp_pkg::S_U_RC: state_in = lufpp_pkg::S_U_WR;
         lufpp_pkg::S_U_WR: begin
            priority if (k_nx < n_ff) begin
               k_in = k_nx; state_in = lufpp_pkg::S_U_RA;
            end else if (j_nx < n_ff) begin
               j_in = j_nx; state_in = lufpp_pkg::S_L_RD;
            end else if (i_nx < n_ff) begin
               i_in = i_nx; j_in = i_nx; state_in = lufpp_pkg::S_PV_RD;
            end else begin
               state_in = lufpp_pkg::S_IDLE;
            end
         end
         default: state_in = lufpp_pkg::S_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd.op      = lufpp_pkg::OP_NONE;
      cmd.first   = (j_ff == i_ff);
      cmd.perm_en = (k_ff == '0);
      unique case (state_ff)
         lufpp_pkg::S_IDLE: begin
            if (fire) begin
               cmd.op = (req_func == lufpp_pkg::FUNC_READ) ? lufpp_pkg::OP_READ
                                                          : lufpp_pkg::OP_LOAD;
            end
         end
         lufpp_pkg::S_RD:     cmd.op = sts.rsp_free ? lufpp_pkg::OP_RSP : lufpp_pkg::OP_NONE;
         lufpp_pkg::S_INIT:   cmd.op = lufpp_pkg::OP_INIT;
         lufpp_pkg::S_PV_RD:  cmd.op = lufpp_pkg::OP_PV_RD;
         lufpp_pkg::S_PV_CMP: cmd.op = lufpp_pkg::OP_PV_CMP;
         lufpp_pkg::S_PV_CHK: cmd.op = sts.bmag_zero ? lufpp_pkg::OP_SING : lufpp_pkg::OP_NONE;
         lufpp_pkg::S_SW_RA:  cmd.op = lufpp_pkg::OP_SW_RA;
         lufpp_pkg::S_SW_RB:  cmd.op = lufpp_pkg::OP_SW_RB;
         lufpp_pkg::S_SW_WA:  cmd.op = lufpp_pkg::OP_SW_WA;
         lufpp_pkg::S_SW_WB:  cmd.op = lufpp_pkg::OP_SW_WB;
         lufpp_pkg::S_PR_RD:  cmd.op = lufpp_pkg::OP_PR_RD;
         lufpp_pkg::S_PR_CAP: cmd.op = lufpp_pkg::OP_PR_CAP;
         lufpp_pkg::S_L_RD:   cmd.op = lufpp_pkg::OP_L_RD;
         lufpp_pkg::S_L_GO:   cmd.op = lufpp_pkg::OP_L_GO;
         lufpp_pkg::S_L_WAIT: cmd.op = lufpp_pkg::OP_NONE;
         lufpp_pkg::S_L_WR:   cmd.op = lufpp_pkg::OP_L_WR;
         lufpp_pkg::S_U_RA:   cmd.op = lufpp_pkg::OP_U_RA;
         lufpp_pkg::S_U_RB:   cmd.op = lufpp_pkg::OP_U_RB;
         lufpp_pkg::S_U_RC:   cmd.op = lufpp_pkg::OP_U_RC;
         lufpp_pkg::S_U_WR:   cmd.op = lufpp_pkg::OP_U_WR;
         default:             cmd.op = lufpp_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lufpp_pkg::S_IDLE;
         n_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
      end
   end

   assign req_ready = (state_ff == lufpp_pkg::S_IDLE);
   assign i_idx = i_ff[IDX_W-1:0];
   assign j_idx = j_ff[IDX_W-1:0];
   assign k_idx = k_ff[IDX_W-1:0];

endmodule : lufpp_ctrl
`default_nettype wire

/* design/lu_factor_partial_pivot.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lu_factor_partial_pivot
// In-place LU factoring with partial row pivoting of a Q16.16 matrix.
// ----------------------------------------------------------------------------
// A load transfer is taken while idle; a read transfer also waits for the
// response slot. A load marked last starts factoring, during which no
// request is taken: per column i a pivot scan over the single matrix read
// port, a row swap, a multiplier for each row below from the bit-serial
// 48-step divider, and a trailing entry update (read, multiply, truncate,
// write back through the single read port and single write port).
// matrix_size must be written only while idle; the block does not enforce it.
module lu_factor_partial_pivot #(
   parameter int MAX_DIM = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_we,
   input  wire logic [4:0] csr_wdata,
   lufpp_req_if.sink   req_if,
   lufpp_rsp_if.source rsp_if
);

   localparam int IDX_W = $clog2(MAX_DIM);

   lufpp_pkg::cmd_type cmd;
   lufpp_pkg::sts_type sts;
   logic [IDX_W-1:0]   i_idx, j_idx, k_idx;

   lufpp_ctrl #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .req_last  (req_if.last),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd),
      .i_idx     (i_idx),
      .j_idx     (j_idx),
      .k_idx     (k_idx)
   );

   lufpp_dp #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .i_idx         (i_idx),
      .j_idx         (j_idx),
      .k_idx         (k_idx),
      .req_row       (req_if.row),
      .req_col       (req_if.col),
      .req_value     (req_if.value),
      .sts           (sts),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_entry     (rsp_if.entry),
      .rsp_pivot_row (rsp_if.pivot_row),
      .rsp_singular  (rsp_if.singular)
   );

endmodule : lu_factor_partial_pivot
`default_nettype wire

/* design/lufpp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lufpp_checker
// Port-level checks of the LU factoring block, bound to its top level.
// ----------------------------------------------------------------------------
module lufpp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_func,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_entry
);

   // a read transfer holds off the next request while the response forms
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == lufpp_pkg::FUNC_READ) |=> !req_ready)
      else $error("request taken right after a read");

   // a final load starts factoring, which blocks requests
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == lufpp_pkg::FUNC_LOAD && req_last)
      |=> !req_ready)
      else $error("request taken right after the final load");

   // a response only appears in the cycle after the block was busy with a read
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without a read");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_entry)))
      else $error("stalled response dropped or changed");

endmodule : lufpp_checker

bind lu_factor_partial_pivot lufpp_checker u_lufpp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_func  (req_if.func),
   .req_last  (req_if.last),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_entry (rsp_if.entry)
);
`default_nettype wire

/* test/lu_factor_partial_pivot_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lu_factor_partial_pivot_tb
// Drives load and read transfers into the LU factoring block, keeps its own
// Q16.16 pivoting LU predictor, and checks every read response field by field
// across several matrix sizes and idle patterns.
// ----------------------------------------------------------------------------
module lu_factor_partial_pivot_tb;

   localparam int DIM = 16;

   typedef struct {
      logic               func;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
      logic               last;
   } lu_req_type;

   typedef struct {
      logic signed [31:0] entry;
      logic [3:0]         pivot_row;
      logic               singular;
   } lu_rsp_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [4:0] csr_wdata;

   lufpp_req_if req_bus ();
   lufpp_rsp_if rsp_bus ();

   lu_factor_partial_pivot #(.MAX_DIM(DIM)) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus.sink),
      .rsp_if    (rsp_bus.source)
   );

   // predictor state
   logic signed [31:0] mat_q [DIM*DIM];
   logic [3:0]         perm_q [DIM];
   logic               sing_q;
   logic [4:0]         size_q;

   lu_req_type pending_reqs[$];
   lu_rsp_type expected_rsps[$];
   lu_req_type cur_req;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int hold_request;
   int mismatches;
   int total_items;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint magnitude(input logic signed [31:0] v);
      longint x;
      x = v;
      return (x < 0) ? -x : x;
   endfunction

   function automatic void factor_matrix();
      int n;
      int best;
      longint bmag;
      longint m;
      longint piv;
      longint a;
      longint p;
      logic signed [31:0] l;
      logic signed [31:0] tv;
      logic [3:0] tp;
      n = size_q;
      if (n == 0) n = 1;
      if (n > DIM) n = DIM;
      for (int i = 0; i < DIM; i++) perm_q[i] = i[3:0];
      sing_q = 1'b0;
      for (int i = 0; i < n; i++) begin
         best = i;
         bmag = magnitude(mat_q[i*DIM+i]);
         for (int t = i + 1; t < n; t++) begin
            m = magnitude(mat_q[t*DIM+i]);
            if (m > bmag) begin
               bmag = m;
               best = t;
            end
         end
         if (bmag == 0) begin
            sing_q = 1'b1;
            continue;
         end
         if (best != i) begin
            tp = perm_q[i];
            perm_q[i] = perm_q[best];
            perm_q[best] = tp;
            for (int j = 0; j < n; j++) begin
               tv = mat_q[i*DIM+j];
               mat_q[i*DIM+j] = mat_q[best*DIM+j];
               mat_q[best*DIM+j] = tv;
            end
         end
         piv = mat_q[i*DIM+i];
         for (int j = i + 1; j < n; j++) begin
            a = mat_q[j*DIM+i];
            l = sat32((a * 65536) / piv);
            mat_q[j*DIM+i] = l;
            for (int k = i + 1; k < n; k++) begin
               p = (longint'(l) * longint'(mat_q[i*DIM+k])) / 65536;
               mat_q[j*DIM+k] = sat32(longint'(mat_q[j*DIM+k]) - p);
            end
         end
      end
   endfunction

   function automatic void apply_request(input lu_req_type r);
      lu_rsp_type e;
      if (r.func == lufpp_pkg::FUNC_LOAD) begin
         mat_q[r.row*DIM+r.col] = r.value;
         if (r.last) factor_matrix();
      end else begin
         e.entry     = mat_q[r.row*DIM+r.col];
         e.pivot_row = perm_q[r.row];
         e.singular  = sing_q;
         expected_rsps.push_back(e);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) apply_request(cur_req);
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_req = pending_reqs.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.func  <= cur_req.func;
            req_bus.row   <= cur_req.row;
            req_bus.col   <= cur_req.col;
            req_bus.value <= cur_req.value;
            req_bus.last  <= cur_req.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stall
   always @(posedge clock) begin
      lu_rsp_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transfer: entry %h pivot_row %0d %s %0d",
                           rsp_bus.entry, rsp_bus.pivot_row, "singular",
                           rsp_bus.singular);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_bus.entry !== e.entry || rsp_bus.pivot_row !== e.pivot_row ||
                   rsp_bus.singular !== e.singular) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"response mismatch: exp entry %h pivot_row %0d ",
                               "singular %0d, got entry %h pivot_row %0d singular %0d"},
                              e.entry, e.pivot_row, e.singular,
                              rsp_bus.entry, rsp_bus.pivot_row, rsp_bus.singular);
               end
            end
         end
         if (hold_request > 0) begin
            hold_cycles = hold_request;
            hold_request = 0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic signed [31:0] pick_value(input int mode);
      case ($urandom_range(mode == 2 ? 5 : 9))
         0: return 32'sh80000000;
         1: return 32'sh7fffffff;
         2: return $urandom();
         3: return 32'sd0;
         default: return (mode == 1) ? $signed(($urandom_range(4) - 2) * 65536)
                                     : $signed($urandom_range(32'h60000) - 32'h30000);
      endcase
   endfunction

   task automatic queue_item(input logic func, input int row, input int col,
                             input logic signed [31:0] value, input logic last);
      lu_req_type r;
      r.func  = func;
      r.row   = row[3:0];
      r.col   = col[3:0];
      r.value = value;
      r.last  = last;
      pending_reqs.push_back(r);
      total_items++;
   endtask

   // mode 0 random, 1 small ties, 2 extremes, 3 zero first column (singular)
   task automatic queue_matrix(input int n, input int mode, input int reads);
      logic signed [31:0] v;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            v = (mode == 3 && c == 0) ? 32'sd0 : pick_value(mode);
            queue_item(lufpp_pkg::FUNC_LOAD, r, c, v, (r == n - 1 && c == n - 1));
         end
      for (int k = 0; k < reads; k++)
         queue_item(lufpp_pkg::FUNC_READ, $urandom_range(15), $urandom_range(15),
                    $urandom(), $urandom_range(1));
      // a read always closes the phase so the block is idle once it returns
      queue_item(lufpp_pkg::FUNC_READ, $urandom_range(n - 1), $urandom_range(n - 1),
                 32'sd0, 1'b0);
   endtask

   // checked between edges so the driver's and monitor's updates have settled
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_bus.valid || expected_rsps.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(input logic [4:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      size_q = v;
   endtask

   task automatic run_phase(input logic [4:0] size_cfg, input int mode, input int reads);
      int n;
      wait_drained();
      write_size(size_cfg);
      n = (size_cfg == 0) ? 1 : (size_cfg > DIM ? DIM : size_cfg);
      queue_matrix(n, mode, reads);
   endtask

   initial begin
      int sz;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.func   = lufpp_pkg::FUNC_LOAD;
      req_bus.row    = '0;
      req_bus.col    = '0;
      req_bus.value  = '0;
      req_bus.last   = 1'b0;
      rsp_bus.ready  = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_request   = 0;
      mismatches     = 0;
      total_items    = 0;
      for (int i = 0; i < DIM*DIM; i++) mat_q[i] = '0;
      for (int i = 0; i < DIM; i++) perm_q[i] = i[3:0];
      sing_q = 1'b0;
      size_q = lufpp_pkg::SIZE_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill the whole store first so no read or factoring sees an unwritten entry
      queue_matrix(DIM, 0, 4);

      // directed: singular, ties, extremes, size 0 and an oversize setting
      run_phase(5'd2, 3, 2);
      run_phase(5'd3, 1, 2);
      run_phase(5'd2, 2, 2);
      run_phase(5'd0, 2, 1);
      run_phase(5'd31, 1, 3);

      // long receiver hold-off while the sender keeps offering reads
      wait_drained();
      hold_request = 300;
      for (int k = 0; k < 12; k++)
         queue_item(lufpp_pkg::FUNC_READ, $urandom_range(15), $urandom_range(15),
                    $urandom(), 1'b0);

      while (total_items < 800) begin
         case ($urandom_range(3))
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         sz = ($urandom_range(19) == 0) ? 16 : $urandom_range(6, 1);
         run_phase(sz[4:0], ($urandom_range(9) == 0) ? 3 : $urandom_range(2),
                   $urandom_range(12, 3));
      end

      wait_drained();
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #30ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule : lu_factor_partial_pivot_tb
